@@ src/pcst_pkg.sv @@
package pcst_pkg;

    // Operation codes carried by func
    localparam logic [2:0] FN_START     = 3'd0;
    localparam logic [2:0] FN_STOP      = 3'd1;
    localparam logic [2:0] FN_RESET     = 3'd2;
    localparam logic [2:0] FN_RESET_ALL = 3'd3;
    localparam logic [2:0] FN_QUERY     = 3'd4;

    // Result status codes
    localparam logic [2:0] STS_OK          = 3'd0;
    localparam logic [2:0] STS_OFF         = 3'd1;
    localparam logic [2:0] STS_RUNNING     = 3'd2;
    localparam logic [2:0] STS_NOT_RUNNING = 3'd3;
    localparam logic [2:0] STS_UNKNOWN     = 3'd4;

    // Configuration register map
    localparam int         CFG_IDX_W       = 1;
    localparam int         CFG_DATA_W      = 16;
    localparam logic [CFG_IDX_W-1:0] REG_PROFILER_ON = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_MASK = 1'd1;

    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

endpackage

@@ src/pcst_ram.sv @@
module pcst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/probe_cycle_statistics_table_unit.sv @@
// Cycle profiler: a table of numbered probes with per-probe statistics.
//
// Command channel: an item (func, probe, timestamp, history_offset) is taken
// at a rising edge with start high and busy low. busy stays high while the
// item is worked on. Each item gives exactly one result, shown on the result
// ports for one cycle with done high; the receiver cannot stall, so the
// result is simply taken at the end of that cycle. busy falls in the same
// cycle that done rises, so the next item may start right then.
//
// Items never overlap: a new item is taken only once the last one is done.
// Start, reset, reset-all and status-only answers go from decode straight
// to finish; a stop of a running probe passes through the DIFF, MIN and MAX
// states, and a query through the bit-serial 64-by-32 average division, one
// quotient bit per cycle through the single 33-bit subtractor that every step shares.
//
// Configuration channel: cfg_valid/cfg_ready with cfg_index and cfg_data;
// register 0 is profiler_on, register 1 is the probe enable mask; cfg_ready
// is tied high. Reset turns the profiler off, enables every probe and leaves
// all probes idle, unseen and cleared: statistics rows carry a valid bit each
// and the history fill count, so neither reset nor reset-all needs a pass.
module probe_cycle_statistics_table_unit
    import pcst_pkg::*;
#(
    parameter int NUM_PROBES    = 16,
    parameter int HISTORY_DEPTH = 8
) (
    input  logic                  clk,
    input  logic                  rst_n,
    // command channel
    input  logic                  start,
    output logic                  busy,
    input  logic [2:0]            func,
    input  logic [3:0]            probe,
    input  logic [31:0]           timestamp,
    input  logic [2:0]            history_offset,
    // result channel
    output logic                  done,
    output logic [2:0]            status,
    output logic [31:0]           measured_cycles,
    output logic [31:0]           calls_seen,
    output logic [31:0]           average_cycles,
    output logic [31:0]           least_cycles,
    output logic [31:0]           most_cycles,
    output logic [31:0]           history_value,
    // configuration channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW = (NUM_PROBES > 1) ? $clog2(NUM_PROBES) : 1;
    localparam int HW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int STAT_DEPTH = 1 << PW;
    localparam int HIST_DEPTH = 1 << (PW + HW);

    // Sequencer states
    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIFF   = 3'd2;
    localparam logic [2:0] ST_MIN    = 3'd3;
    localparam logic [2:0] ST_MAX    = 3'd4;
    localparam logic [2:0] ST_DIV    = 3'd5;
    localparam logic [2:0] ST_FINISH = 3'd6;

    // One statistics row per probe. wrap and pos form the fill count of the
    // probe's history ring: slot s holds data only if wrap or s < pos.
    typedef struct packed {
        logic [31:0]   cnt;
        logic [63:0]   sum;
        logic [31:0]   min_v;
        logic [31:0]   max_v;
        logic          wrap;
        logic [HW-1:0] pos;
    } stat_row_t;

    localparam int ROW_W = $bits(stat_row_t);

    // (pos + offset) mod HISTORY_DEPTH; the sum stays below HISTORY_DEPTH + 8
    function automatic logic [HW-1:0] ring_slot(input logic [HW-1:0] pos,
                                                input logic [2:0]    off);
        logic [6:0] s;
        s = 7'(pos) + 7'(off);
        for (int i = 0; i < 8; i++)
        begin
            if (s >= 7'(HISTORY_DEPTH))
            begin
                s = s - 7'(HISTORY_DEPTH);
            end
        end
        return HW'(s);
    endfunction

    // control state
    logic [2:0]            state_reg, state_next;
    logic                  done_reg, done_next;
    logic                  on_reg, on_next;
    logic [CFG_DATA_W-1:0] mask_reg, mask_next;
    logic [NUM_PROBES-1:0] seen_reg, seen_next;
    logic [NUM_PROBES-1:0] active_reg, active_next;
    logic [NUM_PROBES-1:0] row_valid_reg, row_valid_next;

    // item and working registers
    logic [2:0]    func_reg, func_next;
    logic [PW-1:0] pidx_reg, pidx_next;
    logic          in_range_reg, in_range_next;
    logic [31:0]   ts_reg, ts_next;
    logic [2:0]    off_reg, off_next;
    logic [2:0]    code_reg, code_next;
    logic [31:0]   cnt_reg, cnt_next;
    logic [63:0]   sum_reg, sum_next;
    logic [31:0]   min_reg, min_next;
    logic [31:0]   max_reg, max_next;
    logic [HW-1:0] pos_reg, pos_next;
    logic          wrap_reg, wrap_next;
    logic [31:0]   meas_reg, meas_next;
    logic          hist_ok_reg, hist_ok_next;
    logic [31:0]   rem_reg, rem_next;
    logic [63:0]   quo_reg, quo_next;
    logic [5:0]    iter_reg, iter_next;

    // result registers
    logic [2:0]  res_status_reg, res_status_next;
    logic [31:0] res_meas_reg, res_meas_next;
    logic [31:0] res_calls_reg, res_calls_next;
    logic [31:0] res_avg_reg, res_avg_next;
    logic [31:0] res_min_reg, res_min_next;
    logic [31:0] res_max_reg, res_max_next;
    logic [31:0] res_hist_reg, res_hist_next;

    // shared subtractor
    logic [32:0] alu_a, alu_b;
    logic [33:0] alu_diff;
    logic        alu_borrow;

    // memory ports
    logic                   stat_wr_en, stat_rd_en;
    logic [PW-1:0]          stat_wr_addr, stat_rd_addr;
    stat_row_t              stat_wr_row, stat_rd_row, cur_row;
    logic [ROW_W-1:0]       stat_rd_data;
    logic                   stamp_wr_en, stamp_rd_en;
    logic [PW-1:0]          stamp_wr_addr, stamp_rd_addr;
    logic [31:0]            stamp_rd_data;
    logic                   hist_wr_en, hist_rd_en;
    logic [PW+HW-1:0]       hist_wr_addr, hist_rd_addr;
    logic [31:0]            hist_rd_data;

    logic [HW-1:0] q_slot;
    logic [HW-1:0] pos_inc;
    logic          q_bit;

    assign alu_diff   = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_borrow = alu_diff[33];

    assign stat_rd_row = stat_rd_data;
    assign q_slot      = ring_slot(cur_row.pos, off_reg);
    assign pos_inc     = HW'(pos_reg + 1'b1);

    assign busy      = (state_reg != ST_IDLE);
    assign cfg_ready = 1'b1;

    assign done            = done_reg;
    assign status          = res_status_reg;
    assign measured_cycles = res_meas_reg;
    assign calls_seen      = res_calls_reg;
    assign average_cycles  = res_avg_reg;
    assign least_cycles    = res_min_reg;
    assign most_cycles     = res_max_reg;
    assign history_value   = res_hist_reg;

    // A row whose valid bit is down reads as a cleared row.
    always_comb
    begin
        if (row_valid_reg[pidx_reg])
        begin
            cur_row = stat_rd_row;
        end
        else
        begin
            cur_row.cnt   = '0;
            cur_row.sum   = '0;
            cur_row.min_v = ALL_ONES;
            cur_row.max_v = '0;
            cur_row.wrap  = 1'b0;
            cur_row.pos   = '0;
        end
    end

    // Configuration writes
    always_comb
    begin
        on_next   = on_reg;
        mask_next = mask_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PROFILER_ON: on_next   = cfg_data[0];
                REG_ENABLE_MASK: mask_next = cfg_data;
                default:         ;
            endcase
        end
    end

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        done_next       = 1'b0;
        seen_next       = seen_reg;
        active_next     = active_reg;
        row_valid_next  = row_valid_reg;

        func_next       = func_reg;
        pidx_next       = pidx_reg;
        in_range_next   = in_range_reg;
        ts_next         = ts_reg;
        off_next        = off_reg;
        code_next       = code_reg;
        cnt_next        = cnt_reg;
        sum_next        = sum_reg;
        min_next        = min_reg;
        max_next        = max_reg;
        pos_next        = pos_reg;
        wrap_next       = wrap_reg;
        meas_next       = meas_reg;
        hist_ok_next    = hist_ok_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        iter_next       = iter_reg;

        res_status_next = res_status_reg;
        res_meas_next   = res_meas_reg;
        res_calls_next  = res_calls_reg;
        res_avg_next    = res_avg_reg;
        res_min_next    = res_min_reg;
        res_max_next    = res_max_reg;
        res_hist_next   = res_hist_reg;

        alu_a = '0;
        alu_b = '0;
        q_bit = 1'b0;

        stat_rd_en    = 1'b0;
        stat_rd_addr  = PW'(probe);
        stat_wr_en    = 1'b0;
        stat_wr_addr  = pidx_reg;
        stat_wr_row   = cur_row;
        stamp_rd_en   = 1'b0;
        stamp_rd_addr = PW'(probe);
        stamp_wr_en   = 1'b0;
        stamp_wr_addr = pidx_reg;
        hist_rd_en    = 1'b0;
        hist_rd_addr  = {pidx_reg, q_slot};
        hist_wr_en    = 1'b0;
        hist_wr_addr  = {pidx_reg, pos_reg};

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    // latch the item and fetch the probe's row and stamp
                    func_next     = func;
                    pidx_next     = PW'(probe);
                    in_range_next = (7'(probe) < 7'(NUM_PROBES));
                    ts_next       = timestamp;
                    off_next      = history_offset;
                    stat_rd_en    = 1'b1;
                    stamp_rd_en   = 1'b1;
                    state_next    = ST_DECODE;
                end
            end

            ST_DECODE:
            begin
                cnt_next     = cur_row.cnt;
                sum_next     = cur_row.sum;
                min_next     = cur_row.min_v;
                max_next     = cur_row.max_v;
                pos_next     = cur_row.pos;
                wrap_next    = cur_row.wrap;
                code_next    = STS_OK;
                meas_next    = '0;
                hist_ok_next = 1'b0;
                quo_next     = '0;
                state_next   = ST_FINISH;
                case (func_reg)
                    FN_START, FN_STOP:
                    begin
                        if (!on_reg)
                        begin
                            code_next = STS_OFF;
                        end
                        else if (!in_range_reg)
                        begin
                            code_next = STS_UNKNOWN;
                        end
                        else
                        begin
                            seen_next[pidx_reg] = 1'b1;
                            if (mask_reg[4'(pidx_reg)])
                            begin
                                if (func_reg == FN_START)
                                begin
                                    if (active_reg[pidx_reg])
                                    begin
                                        code_next = STS_RUNNING;
                                    end
                                    else
                                    begin
                                        stamp_wr_en           = 1'b1;
                                        active_next[pidx_reg] = 1'b1;
                                    end
                                end
                                else if (!active_reg[pidx_reg])
                                begin
                                    code_next = STS_NOT_RUNNING;
                                end
                                else
                                begin
                                    state_next = ST_DIFF;
                                end
                            end
                        end
                    end

                    FN_RESET:
                    begin
                        if (!in_range_reg || !seen_reg[pidx_reg])
                        begin
                            code_next = STS_UNKNOWN;
                        end
                        else
                        begin
                            row_valid_next[pidx_reg] = 1'b0;
                            cnt_next = '0;
                            min_next = ALL_ONES;
                            max_next = '0;
                        end
                    end

                    FN_RESET_ALL:
                    begin
                        row_valid_next = '0;
                        cnt_next       = '0;
                        min_next       = ALL_ONES;
                        max_next       = '0;
                    end

                    FN_QUERY:
                    begin
                        if (!on_reg)
                        begin
                            code_next = STS_OFF;
                        end
                        else if (!in_range_reg || !seen_reg[pidx_reg])
                        begin
                            code_next = STS_UNKNOWN;
                        end
                        else
                        begin
                            // fetch the history entry; start the division
                            hist_rd_en   = 1'b1;
                            hist_ok_next = cur_row.wrap || (q_slot < cur_row.pos);
                            quo_next     = cur_row.sum;
                            rem_next     = '0;
                            iter_next    = '1;
                            state_next   = ST_DIV;
                        end
                    end

                    default: ;
                endcase
            end

            ST_DIFF:
            begin
                // wrap-around elapsed cycles
                alu_a      = {1'b0, ts_reg};
                alu_b      = {1'b0, stamp_rd_data};
                meas_next  = alu_diff[31:0];
                state_next = ST_MIN;
            end

            ST_MIN:
            begin
                alu_a    = {1'b0, meas_reg};
                alu_b    = {1'b0, min_reg};
                cnt_next = cnt_reg + 32'd1;
                sum_next = sum_reg + {32'd0, meas_reg};
                if (alu_borrow)
                begin
                    min_next = meas_reg;
                end
                state_next = ST_MAX;
            end

            ST_MAX:
            begin
                alu_a = {1'b0, max_reg};
                alu_b = {1'b0, meas_reg};
                if (alu_borrow)
                begin
                    max_next = meas_reg;
                end
                // append to the ring and advance the fill count
                if ((7'(pos_reg) + 7'd1) == 7'(HISTORY_DEPTH))
                begin
                    pos_next  = '0;
                    wrap_next = 1'b1;
                end
                else
                begin
                    pos_next = pos_inc;
                end
                hist_wr_en = 1'b1;
                stat_wr_en = 1'b1;
                stat_wr_row.cnt   = cnt_reg;
                stat_wr_row.sum   = sum_reg;
                stat_wr_row.min_v = min_reg;
                stat_wr_row.max_v = alu_borrow ? meas_reg : max_reg;
                stat_wr_row.wrap  = wrap_next;
                stat_wr_row.pos   = pos_next;
                row_valid_next[pidx_reg] = 1'b1;
                active_next[pidx_reg]    = 1'b0;
                state_next = ST_FINISH;
            end

            ST_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    quo_next   = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    // restoring step: shift in the next dividend bit
                    alu_a = {rem_reg, quo_reg[63]};
                    alu_b = {1'b0, cnt_reg};
                    q_bit = !alu_borrow;
                    if (q_bit)
                    begin
                        rem_next = alu_diff[31:0];
                    end
                    else
                    begin
                        rem_next = {rem_reg[30:0], quo_reg[63]};
                    end
                    quo_next  = {quo_reg[62:0], q_bit};
                    iter_next = iter_reg - 6'd1;
                    if (iter_reg == '0)
                    begin
                        state_next = ST_FINISH;
                    end
                end
            end

            ST_FINISH:
            begin
                done_next       = 1'b1;
                res_status_next = code_reg;
                res_meas_next   = meas_reg;
                res_calls_next  = in_range_reg ? cnt_reg : 32'd0;
                res_min_next    = in_range_reg ? min_reg : ALL_ONES;
                res_max_next    = in_range_reg ? max_reg : 32'd0;
                res_avg_next    = quo_reg[31:0];
                res_hist_next   = hist_ok_reg ? hist_rd_data : 32'd0;
                state_next      = ST_IDLE;
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            done_reg      <= 1'b0;
            on_reg        <= 1'b0;
            mask_reg      <= '1;
            seen_reg      <= '0;
            active_reg    <= '0;
            row_valid_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            on_reg        <= on_next;
            mask_reg      <= mask_next;
            seen_reg      <= seen_next;
            active_reg    <= active_next;
            row_valid_reg <= row_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        pidx_reg       <= pidx_next;
        in_range_reg   <= in_range_next;
        ts_reg         <= ts_next;
        off_reg        <= off_next;
        code_reg       <= code_next;
        cnt_reg        <= cnt_next;
        sum_reg        <= sum_next;
        min_reg        <= min_next;
        max_reg        <= max_next;
        pos_reg        <= pos_next;
        wrap_reg       <= wrap_next;
        meas_reg       <= meas_next;
        hist_ok_reg    <= hist_ok_next;
        rem_reg        <= rem_next;
        quo_reg        <= quo_next;
        iter_reg       <= iter_next;
        res_status_reg <= res_status_next;
        res_meas_reg   <= res_meas_next;
        res_calls_reg  <= res_calls_next;
        res_avg_reg    <= res_avg_next;
        res_min_reg    <= res_min_next;
        res_max_reg    <= res_max_next;
        res_hist_reg   <= res_hist_next;
    end

    // Per-probe statistics rows
    pcst_ram #(
        .WIDTH (ROW_W),
        .DEPTH (STAT_DEPTH)
    ) u_stat_ram (
        .clk     (clk),
        .wr_en   (stat_wr_en),
        .wr_addr (stat_wr_addr),
        .wr_data (stat_wr_row),
        .rd_en   (stat_rd_en),
        .rd_addr (stat_rd_addr),
        .rd_data (stat_rd_data)
    );

    // Start stamps, kept across statistics resets
    pcst_ram #(
        .WIDTH (32),
        .DEPTH (STAT_DEPTH)
    ) u_stamp_ram (
        .clk     (clk),
        .wr_en   (stamp_wr_en),
        .wr_addr (stamp_wr_addr),
        .wr_data (ts_reg),
        .rd_en   (stamp_rd_en),
        .rd_addr (stamp_rd_addr),
        .rd_data (stamp_rd_data)
    );

    // History rings, one row of slots per probe
    pcst_ram #(
        .WIDTH (32),
        .DEPTH (HIST_DEPTH)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (hist_wr_addr),
        .wr_data (meas_reg),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

endmodule
